/* rtl/core/tcsm_pkg.sv */
// shared types and constants for the tcp connection state machine
package tcsm_pkg;

  localparam int unsigned InDataW  = 152;
  localparam int unsigned InUserW  = 3;
  localparam int unsigned OutDataW = 176;
  localparam int unsigned OutUserW = 1;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  localparam logic [15:0] EPH_FIRST = 16'd49152;
  localparam logic [15:0] EPH_END   = 16'd65535;

  localparam logic [15:0] RCV_WIN_RST  = 16'd65535;
  localparam logic [15:0] SND_LIM_RST  = 16'd65535;
  localparam logic [31:0] ACT_ISN_RST  = 32'd1000;
  localparam logic [31:0] PAS_ISN_RST  = 32'd2000;

  // flag bit positions
  localparam int unsigned FIN_BIT = 0;
  localparam int unsigned SYN_BIT = 1;
  localparam int unsigned ACK_BIT = 4;

  localparam logic [7:0] FL_FIN = 8'h01;
  localparam logic [7:0] FL_SYN = 8'h02;
  localparam logic [7:0] FL_PSH = 8'h08;
  localparam logic [7:0] FL_ACK = 8'h10;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RCV_WIN = 2'd0,
    CFG_SND_LIM = 2'd1,
    CFG_ACT_ISN = 2'd2,
    CFG_PAS_ISN = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    PH_CLOSED     = 4'd0,
    PH_LISTEN     = 4'd1,
    PH_SYN_SENT   = 4'd2,
    PH_SYN_RCVD   = 4'd3,
    PH_ESTAB      = 4'd4,
    PH_FIN_WAIT1  = 4'd5,
    PH_FIN_WAIT2  = 4'd6,
    PH_CLOSE_WAIT = 4'd7,
    PH_CLOSING    = 4'd8,
    PH_LAST_ACK   = 4'd9,
    PH_TIME_WAIT  = 4'd10
  } phase_e;

  typedef enum logic [2:0] {
    ACT_ACTIVE_OPEN  = 3'd0,
    ACT_PASSIVE_OPEN = 3'd1,
    ACT_CLOSE        = 3'd2,
    ACT_SEGMENT      = 3'd3,
    ACT_SEND         = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_REJECTED  = 2'd1,
    ST_NO_MATCH  = 2'd2
  } status_e;

  typedef struct packed {
    logic [15:0] rcv_win;
    logic [15:0] snd_lim;
    logic [31:0] act_isn;
    logic [31:0] pas_isn;
  } cfg_t;

  typedef struct packed {
    phase_e      phase;
    logic [15:0] local_port;
    logic [15:0] remote_port;
    logic [31:0] remote_addr;
    logic [31:0] send_next;
    logic [31:0] recv_next;
    logic [15:0] next_eph;
  } conn_t;

  typedef struct packed {
    action_e     action;
    logic [31:0] peer_addr;
    logic [15:0] peer_port;
    logic [15:0] own_port;
    logic [7:0]  seg_flags;
    logic [31:0] seg_seq;
    logic [31:0] seg_ack;
    logic [15:0] payload_len;
  } item_t;

  typedef struct packed {
    logic        emit;
    logic [7:0]  out_flags;
    logic [31:0] out_seq;
    logic [31:0] out_ack;
    logic [15:0] out_window;
    logic [15:0] out_src_port;
    logic [15:0] out_dst_port;
    logic [31:0] out_dst_addr;
    logic [15:0] out_len;
    logic [3:0]  conn_state;
    status_e     status;
  } result_t;

endpackage

/* rtl/core/tcp_connection_state_machine_top.sv */
// Header-level engine for a single TCP connection.
// Slave stream: tuser carries the action (open, close, segment, send), tdata the
// segment or request fields. Master stream: one transfer per accepted item with
// the new connection state, a status and, when tuser (emit) is set, the header
// to send. The user must load registers on the cfg write port only while no item
// is in flight; the block does not enforce it. An accepted item is captured in
// the input register and evaluated against the connection state, and its result
// is registered in the output register. Throughput: one item per cycle unless
// the receiver stalls; the connection state register is read and written by the
// combinational transition logic, so item n+1 sees item n's state.
// When the receiver stalls, the result waits in the output register and the
// input register still holds one more item; tready drops only when both are full.
// Reset puts the connection in Closed, clears ports, address and sequence
// numbers, sets the ephemeral port counter to 49152 and the registers to their
// defaults; no result is pending after reset.
module tcp_connection_state_machine_top
  import tcsm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // peer_addr, peer_port, own_port, seg_flags, seg_seq, seg_ack, payload_len
  input  logic [InDataW-1:0]  s_axis_tdata,
  // action
  input  logic [InUserW-1:0]  s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // out_flags, out_seq, out_ack, out_window, out_src_port, out_dst_port,
  // out_dst_addr, out_len, conn_state, status, 2 zero bits
  output logic [OutDataW-1:0] m_axis_tdata,
  // emit
  output logic [OutUserW-1:0] m_axis_tuser,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  cfg_t    cfg;
  item_t   item_q;
  logic    in_vld_q;
  conn_t   conn_q;
  conn_t   conn_d;
  result_t res_d;
  result_t res_q;
  logic    out_vld_q;
  logic    advance;

  tcsm_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item_q.action      <= action_e'(s_axis_tuser);
      item_q.peer_addr   <= s_axis_tdata[31:0];
      item_q.peer_port   <= s_axis_tdata[47:32];
      item_q.own_port    <= s_axis_tdata[63:48];
      item_q.seg_flags   <= s_axis_tdata[71:64];
      item_q.seg_seq     <= s_axis_tdata[103:72];
      item_q.seg_ack     <= s_axis_tdata[135:104];
      item_q.payload_len <= s_axis_tdata[151:136];
    end
  end

  tcsm_engine u_engine (
    .cfg_i  (cfg),
    .conn_i (conn_q),
    .item_i (item_q),
    .conn_o (conn_d),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conn_q.phase       <= PH_CLOSED;
      conn_q.local_port  <= '0;
      conn_q.remote_port <= '0;
      conn_q.remote_addr <= '0;
      conn_q.send_next   <= '0;
      conn_q.recv_next   <= '0;
      conn_q.next_eph    <= EPH_FIRST;
    end else if (advance) begin
      conn_q <= conn_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = res_q.emit;
  assign m_axis_tdata  = {2'b00, res_q.status, res_q.conn_state, res_q.out_len,
                          res_q.out_dst_addr, res_q.out_dst_port, res_q.out_src_port,
                          res_q.out_window, res_q.out_ack, res_q.out_seq,
                          res_q.out_flags};

endmodule

/* rtl/core/tcsm_cfg_regs.sv */
// configuration registers written through the plain write port
module tcsm_cfg_regs
  import tcsm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rcv_win <= RCV_WIN_RST;
      cfg_q.snd_lim <= SND_LIM_RST;
      cfg_q.act_isn <= ACT_ISN_RST;
      cfg_q.pas_isn <= PAS_ISN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_RCV_WIN: cfg_q.rcv_win <= cfg_data_i[15:0];
        CFG_SND_LIM: cfg_q.snd_lim <= cfg_data_i[15:0];
        CFG_ACT_ISN: cfg_q.act_isn <= cfg_data_i;
        CFG_PAS_ISN: cfg_q.pas_isn <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/core/tcsm_engine.sv */
// transition logic: one item against the connection state gives next state and result
module tcsm_engine
  import tcsm_pkg::*;
(
  input  cfg_t    cfg_i,
  input  conn_t   conn_i,
  input  item_t   item_i,
  output conn_t   conn_o,
  output result_t res_o
);

  conn_t       nxt;
  logic        emit;
  logic [7:0]  hdr_flags;
  logic [31:0] hdr_seq;
  logic [15:0] hdr_len;
  status_e     status;
  logic        seg_match;
  logic [15:0] eph_inc;
  logic [15:0] snd_len;
  logic [31:0] seq_plus1;
  logic        fl_fin;
  logic        fl_syn;
  logic        fl_ack;

  assign fl_fin    = item_i.seg_flags[FIN_BIT];
  assign fl_syn    = item_i.seg_flags[SYN_BIT];
  assign fl_ack    = item_i.seg_flags[ACK_BIT];
  assign seq_plus1 = item_i.seg_seq + 32'd1;
  assign eph_inc   = conn_i.next_eph + 16'd1;
  assign snd_len   = (item_i.payload_len > cfg_i.snd_lim) ? cfg_i.snd_lim
                                                          : item_i.payload_len;

  always_comb begin
    seg_match = 1'b0;
    if (conn_i.phase == PH_LISTEN) begin
      seg_match = (item_i.own_port == conn_i.local_port);
    end else if (conn_i.phase != PH_CLOSED) begin
      seg_match = (item_i.peer_addr == conn_i.remote_addr) &&
                  (item_i.peer_port == conn_i.remote_port) &&
                  (item_i.own_port == conn_i.local_port);
    end
  end

  always_comb begin
    nxt       = conn_i;
    emit      = 1'b0;
    hdr_flags = '0;
    hdr_seq   = conn_i.send_next;
    hdr_len   = '0;
    status    = ST_OK;

    unique case (item_i.action)
      ACT_ACTIVE_OPEN: begin
        if (conn_i.phase != PH_CLOSED) begin
          status = ST_REJECTED;
        end else begin
          nxt.local_port  = conn_i.next_eph;
          nxt.next_eph    = (eph_inc == EPH_END || eph_inc < EPH_FIRST) ? EPH_FIRST
                                                                        : eph_inc;
          nxt.remote_addr = item_i.peer_addr;
          nxt.remote_port = item_i.peer_port;
          nxt.recv_next   = '0;
          nxt.send_next   = cfg_i.act_isn + 32'd1;
          nxt.phase       = PH_SYN_SENT;
          emit            = 1'b1;
          hdr_flags       = FL_SYN;
          hdr_seq         = cfg_i.act_isn;
        end
      end
      ACT_PASSIVE_OPEN: begin
        if (conn_i.phase != PH_CLOSED) begin
          status = ST_REJECTED;
        end else begin
          nxt.local_port  = item_i.own_port;
          nxt.remote_port = '0;
          nxt.remote_addr = '0;
          nxt.send_next   = '0;
          nxt.recv_next   = '0;
          nxt.phase       = PH_LISTEN;
        end
      end
      ACT_CLOSE: begin
        unique case (conn_i.phase)
          PH_LISTEN, PH_SYN_SENT: nxt.phase = PH_CLOSED;
          PH_SYN_RCVD, PH_ESTAB, PH_CLOSE_WAIT: begin
            emit          = 1'b1;
            hdr_flags     = FL_FIN | FL_ACK;
            nxt.send_next = conn_i.send_next + 32'd1;
            nxt.phase     = (conn_i.phase == PH_CLOSE_WAIT) ? PH_LAST_ACK : PH_FIN_WAIT1;
          end
          default: status = ST_REJECTED;
        endcase
      end
      ACT_SEGMENT: begin
        if (!seg_match) begin
          status = ST_NO_MATCH;
        end else begin
          unique case (conn_i.phase)
            PH_LISTEN: begin
              if (fl_syn) begin
                nxt.remote_addr = item_i.peer_addr;
                nxt.remote_port = item_i.peer_port;
                nxt.recv_next   = seq_plus1;
                nxt.send_next   = cfg_i.pas_isn + 32'd1;
                nxt.phase       = PH_SYN_RCVD;
                emit            = 1'b1;
                hdr_flags       = FL_SYN | FL_ACK;
                hdr_seq         = cfg_i.pas_isn;
              end
            end
            PH_SYN_SENT: begin
              if (fl_syn && fl_ack) begin
                nxt.recv_next = seq_plus1;
                nxt.phase     = PH_ESTAB;
                emit          = 1'b1;
                hdr_flags     = FL_ACK;
              end
            end
            PH_SYN_RCVD: begin
              if (fl_ack) nxt.phase = PH_ESTAB;
            end
            PH_ESTAB: begin
              if (fl_fin) begin
                nxt.recv_next = seq_plus1;
                nxt.phase     = PH_CLOSE_WAIT;
                emit          = 1'b1;
                hdr_flags     = FL_ACK;
              end else if (fl_ack && item_i.payload_len != '0) begin
                // data segment: advance receive edge and ack it
                nxt.recv_next = conn_i.recv_next + 32'(item_i.payload_len);
                emit          = 1'b1;
                hdr_flags     = FL_ACK;
              end
            end
            PH_FIN_WAIT1: begin
              if (fl_fin) begin
                nxt.recv_next = seq_plus1;
                nxt.phase     = fl_ack ? PH_TIME_WAIT : PH_CLOSING;
                emit          = 1'b1;
                hdr_flags     = FL_ACK;
              end else if (fl_ack) begin
                nxt.phase = PH_FIN_WAIT2;
              end
            end
            PH_FIN_WAIT2: begin
              if (fl_fin) begin
                nxt.recv_next = seq_plus1;
                nxt.phase     = PH_TIME_WAIT;
                emit          = 1'b1;
                hdr_flags     = FL_ACK;
              end
            end
            PH_CLOSING: begin
              if (fl_ack) nxt.phase = PH_TIME_WAIT;
            end
            PH_LAST_ACK: begin
              if (fl_ack) nxt.phase = PH_CLOSED;
            end
            default: ;
          endcase
        end
      end
      ACT_SEND: begin
        if (conn_i.phase != PH_ESTAB) begin
          status = ST_REJECTED;
        end else begin
          emit          = 1'b1;
          hdr_flags     = FL_PSH | FL_ACK;
          hdr_len       = snd_len;
          nxt.send_next = conn_i.send_next + 32'(snd_len);
        end
      end
      default: status = ST_REJECTED;
    endcase
  end

  always_comb begin
    res_o = '0;
    if (emit) begin
      res_o.emit         = 1'b1;
      res_o.out_flags    = hdr_flags;
      res_o.out_seq      = hdr_seq;
      res_o.out_ack      = nxt.recv_next;
      res_o.out_window   = cfg_i.rcv_win;
      res_o.out_src_port = nxt.local_port;
      res_o.out_dst_port = nxt.remote_port;
      res_o.out_dst_addr = nxt.remote_addr;
      res_o.out_len      = hdr_len;
    end
    res_o.conn_state = nxt.phase;
    res_o.status     = status;
  end

  assign conn_o = nxt;

endmodule

/* tb/sv/tcp_connection_state_machine_top_test.sv */
// self-checking stream testbench for the tcp connection state machine top level
module tcp_connection_state_machine_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tcsm_pkg::*;

  localparam logic [2:0] ACT_BAD_LO = 3'd5;
  localparam logic [2:0] ACT_BAD_HI = 3'd7;
  localparam logic [7:0] FL_RST = 8'h04;
  localparam int unsigned PHASE_ITEMS = 224;
  localparam int unsigned SWEEP_OPENS = 8;
  localparam int unsigned DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [2:0]  act;
    logic [31:0] addr;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [7:0]  fl;
    logic [31:0] seq;
    logic [31:0] ack;
    logic [15:0] len;
  } conn_req_t;

  typedef struct {
    phase_e      ph;
    logic [15:0] lport;
    logic [15:0] rport;
    logic [15:0] eph;
    logic [31:0] raddr;
    logic [31:0] snd_nxt;
    logic [31:0] snd_una;
    logic [31:0] rcv_nxt;
  } conn_shadow_t;

  typedef struct {
    conn_req_t req;
    bit        typed;
    result_t   res;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic [InUserW-1:0]  s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [OutUserW-1:0] m_axis_tuser;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  conn_shadow_t sh;
  logic [15:0]  rcv_win = RCV_WIN_RST;
  logic [15:0]  snd_lim = SND_LIM_RST;
  logic [31:0]  act_isn = ACT_ISN_RST;
  logic [31:0]  pas_isn = PAS_ISN_RST;
  result_t      pending_results[$];
  dir_row_t     dir_rows[$];
  int           n_fail = 0;
  int           snd_idle_pct = 32;
  int           rcv_idle_pct = 64;

  tcp_connection_state_machine_top dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #10 clk = ~clk;

  function automatic conn_req_t req(logic [2:0] act, logic [31:0] addr, logic [15:0] sport,
                                    logic [15:0] dport, logic [7:0] fl, logic [31:0] seq,
                                    logic [31:0] ack, logic [15:0] len);
    return conn_req_t'{act, addr, sport, dport, fl, seq, ack, len};
  endfunction

  function automatic result_t quiet(phase_e ph, status_e st);
    result_t r = '0;
    r.conn_state = ph;
    r.status = st;
    return r;
  endfunction

  function automatic result_t header(logic [7:0] fl, logic [15:0] len);
    return result_t'{1'b1, fl, sh.snd_nxt, sh.rcv_nxt, rcv_win, sh.lport, sh.rport,
                     sh.raddr, len, 4'd0, ST_OK};
  endfunction

  // advances the shadow connection by one item and returns the header it causes
  function automatic result_t conn_advance(conn_req_t q);
    result_t     r = '0;
    status_e     st = ST_OK;
    logic [15:0] nxt;
    logic [15:0] amt;
    logic        hit;
    case (q.act)
      ACT_ACTIVE_OPEN: begin
        if (sh.ph != PH_CLOSED) begin
          st = ST_REJECTED;
        end else begin
          sh.lport = sh.eph;
          nxt = sh.eph + 16'd1;
          sh.eph = (nxt >= EPH_END || nxt < EPH_FIRST) ? EPH_FIRST : nxt;
          sh.raddr = q.addr;
          sh.rport = q.sport;
          sh.snd_una = act_isn;
          sh.snd_nxt = act_isn;
          sh.rcv_nxt = '0;
          sh.ph = PH_SYN_SENT;
          r = header(FL_SYN, '0);
          sh.snd_nxt += 32'd1;
        end
      end
      ACT_PASSIVE_OPEN: begin
        if (sh.ph != PH_CLOSED) begin
          st = ST_REJECTED;
        end else begin
          sh.lport = q.dport;
          sh.rport = '0;
          sh.raddr = '0;
          sh.snd_nxt = '0;
          sh.snd_una = '0;
          sh.rcv_nxt = '0;
          sh.ph = PH_LISTEN;
        end
      end
      ACT_CLOSE: begin
        if (sh.ph == PH_LISTEN || sh.ph == PH_SYN_SENT) begin
          sh.ph = PH_CLOSED;
        end else if (sh.ph == PH_SYN_RCVD || sh.ph == PH_ESTAB) begin
          r = header(FL_FIN | FL_ACK, '0);
          sh.snd_nxt += 32'd1;
          sh.ph = PH_FIN_WAIT1;
        end else if (sh.ph == PH_CLOSE_WAIT) begin
          r = header(FL_FIN | FL_ACK, '0);
          sh.snd_nxt += 32'd1;
          sh.ph = PH_LAST_ACK;
        end else begin
          st = ST_REJECTED;
        end
      end
      ACT_SEGMENT: begin
        if (sh.ph == PH_CLOSED) hit = 1'b0;
        else if (sh.ph == PH_LISTEN) hit = (q.dport == sh.lport);
        else hit = (q.addr == sh.raddr) && (q.sport == sh.rport) && (q.dport == sh.lport);
        if (!hit) begin
          st = ST_NO_MATCH;
        end else begin
          case (sh.ph)
            PH_LISTEN: begin
              if ((q.fl & FL_SYN) != 0) begin
                // remote side comes from the segment source
                sh.raddr = q.addr;
                sh.rport = q.sport;
                sh.rcv_nxt = q.seq + 32'd1;
                sh.snd_una = pas_isn;
                sh.snd_nxt = pas_isn;
                r = header(FL_SYN | FL_ACK, '0);
                sh.snd_nxt += 32'd1;
                sh.ph = PH_SYN_RCVD;
              end
            end
            PH_SYN_SENT: begin
              if ((q.fl & (FL_SYN | FL_ACK)) == (FL_SYN | FL_ACK)) begin
                sh.rcv_nxt = q.seq + 32'd1;
                sh.snd_una = q.ack;
                r = header(FL_ACK, '0);
                sh.ph = PH_ESTAB;
              end
            end
            PH_SYN_RCVD: begin
              if ((q.fl & FL_ACK) != 0) begin
                sh.snd_una = q.ack;
                sh.ph = PH_ESTAB;
              end
            end
            PH_ESTAB: begin
              if ((q.fl & FL_FIN) != 0) begin
                sh.rcv_nxt = q.seq + 32'd1;
                r = header(FL_ACK, '0);
                sh.ph = PH_CLOSE_WAIT;
              end else if ((q.fl & FL_ACK) != 0) begin
                sh.snd_una = q.ack;
                if (q.len != 0) begin
                  sh.rcv_nxt += {16'd0, q.len};
                  r = header(FL_ACK, '0);
                end
              end
            end
            PH_FIN_WAIT1: begin
              if ((q.fl & FL_ACK) != 0 && (q.fl & FL_FIN) != 0) begin
                sh.rcv_nxt = q.seq + 32'd1;
                r = header(FL_ACK, '0);
                sh.ph = PH_TIME_WAIT;
              end else if ((q.fl & FL_ACK) != 0) begin
                sh.ph = PH_FIN_WAIT2;
              end else if ((q.fl & FL_FIN) != 0) begin
                sh.rcv_nxt = q.seq + 32'd1;
                r = header(FL_ACK, '0);
                sh.ph = PH_CLOSING;
              end
            end
            PH_FIN_WAIT2: begin
              if ((q.fl & FL_FIN) != 0) begin
                sh.rcv_nxt = q.seq + 32'd1;
                r = header(FL_ACK, '0);
                sh.ph = PH_TIME_WAIT;
              end
            end
            PH_CLOSING: if ((q.fl & FL_ACK) != 0) sh.ph = PH_TIME_WAIT;
            PH_LAST_ACK: if ((q.fl & FL_ACK) != 0) sh.ph = PH_CLOSED;
            default: ;
          endcase
        end
      end
      ACT_SEND: begin
        if (sh.ph != PH_ESTAB) begin
          st = ST_REJECTED;
        end else begin
          amt = (q.len > snd_lim) ? snd_lim : q.len;
          r = header(FL_PSH | FL_ACK, amt);
          sh.snd_nxt += {16'd0, amt};
        end
      end
      default: st = ST_REJECTED;
    endcase
    r.conn_state = sh.ph;
    r.status = st;
    return r;
  endfunction

  function automatic logic [31:0] pick32();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick16();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  function automatic conn_req_t own_seg(logic [7:0] fl);
    return req(ACT_SEGMENT, sh.raddr, sh.rport, sh.lport, fl, pick32(), pick32(), pick16());
  endfunction

  // arbitrary item, half the time aimed at this connection's address and ports
  function automatic conn_req_t stray_item(logic [7:0] mask);
    conn_req_t q;
    q = req(3'($urandom_range(7)), pick32(), pick16(), pick16(), 8'($urandom) & mask,
            pick32(), pick32(), pick16());
    if ($urandom_range(1)) q.act = ACT_SEGMENT;
    if ($urandom_range(1)) begin
      q.addr = sh.raddr;
      q.sport = sh.rport;
      q.dport = sh.lport;
    end
    return q;
  endfunction

  // mostly the next well-formed step of the handshake or data exchange
  function automatic conn_req_t make_item();
    conn_req_t q;
    int        r;
    r = $urandom_range(99);
    q = own_seg(FL_ACK);
    q.len = '0;
    if (r < 25) begin
      q = stray_item(8'hFF);
      // an active close leads to time-wait for good, so it waits for the end of the run
      if (q.act == ACT_CLOSE && (sh.ph == PH_SYN_RCVD || sh.ph == PH_ESTAB)) q.act = ACT_SEND;
      return q;
    end
    case (sh.ph)
      PH_CLOSED: begin
        q = req(ACT_PASSIVE_OPEN, pick32(), pick16(), pick16(), 8'($urandom), pick32(),
                pick32(), pick16());
        if (r < 62) q.act = ACT_ACTIVE_OPEN;
      end
      PH_LISTEN: begin
        if (r < 88) begin
          q = req(ACT_SEGMENT, pick32(), pick16(), sh.lport, FL_SYN | 8'($urandom), pick32(),
                  pick32(), pick16());
        end else begin
          q.act = ACT_CLOSE;
        end
      end
      PH_SYN_SENT: begin
        if (r < 88) q.fl = FL_SYN | FL_ACK | 8'($urandom);
        else q.act = ACT_CLOSE;
      end
      PH_SYN_RCVD: q.fl = FL_ACK | 8'($urandom);
      PH_ESTAB: begin
        q.len = ($urandom_range(3) == 0) ? pick16() : 16'($urandom_range(1500));
        if (r < 55) q.act = ACT_SEND;
        else if (r < 88) q.fl = FL_ACK | (8'($urandom) & ~FL_FIN);
        else q.fl = FL_FIN | 8'($urandom);
      end
      PH_CLOSE_WAIT: begin
        if (r < 60) q.act = ACT_CLOSE;
        else if (r < 80) q.act = ACT_SEND;
        else q.len = pick16();
      end
      PH_LAST_ACK: if (r >= 80) q.fl = 8'($urandom) & ~FL_ACK;
      default: ;
    endcase
    return q;
  endfunction

  task automatic dir_row(conn_req_t q, bit typed, result_t r);
    dir_rows.push_back('{q, typed, r});
  endtask

  task automatic offer(conn_req_t q, bit typed, result_t typed_res);
    result_t want;
    while ($urandom_range(99) < snd_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= q.act;
    s_axis_tdata <= {q.len, q.ack, q.seq, q.fl, q.dport, q.sport, q.addr};
    do @(posedge clk); while (!s_axis_tready);
    want = conn_advance(q);
    pending_results.push_back(typed ? typed_res : want);
    @(negedge clk);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic program_regs(logic [15:0] win, logic [15:0] lim, logic [31:0] ai,
                              logic [31:0] pi);
    cfg_idx_e    idx[4] = '{CFG_RCV_WIN, CFG_SND_LIM, CFG_ACT_ISN, CFG_PAS_ISN};
    logic [31:0] val[4] = '{{16'd0, win}, {16'd0, lim}, ai, pi};
    rcv_win = win;
    snd_lim = lim;
    act_isn = ai;
    pas_isn = pi;
    foreach (idx[i]) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= idx[i];
      cfg_data_i <= val[i];
      @(negedge clk);
    end
    cfg_we_i <= 1'b0;
    @(negedge clk);
  endtask

  task automatic cmp(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h got %h", $time, name, want, got);
      n_fail++;
    end
  endtask

  always @(negedge clk) m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);

  always @(posedge clk) begin
    result_t want;
    if (rst_n && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result transfer with nothing pending, expected none got %h", $time,
                 m_axis_tdata);
        n_fail++;
      end else begin
        want = pending_results.pop_front();
        cmp("emit", want.emit, m_axis_tuser[0]);
        cmp("out_flags", want.out_flags, m_axis_tdata[7:0]);
        cmp("out_seq", want.out_seq, m_axis_tdata[39:8]);
        cmp("out_ack", want.out_ack, m_axis_tdata[71:40]);
        cmp("out_window", want.out_window, m_axis_tdata[87:72]);
        cmp("out_src_port", want.out_src_port, m_axis_tdata[103:88]);
        cmp("out_dst_port", want.out_dst_port, m_axis_tdata[119:104]);
        cmp("out_dst_addr", want.out_dst_addr, m_axis_tdata[151:120]);
        cmp("out_len", want.out_len, m_axis_tdata[167:152]);
        cmp("conn_state", want.conn_state, m_axis_tdata[171:168]);
        cmp("status", want.status, m_axis_tdata[173:172]);
        cmp("pad", '0, m_axis_tdata[175:174]);
      end
    end
  end

  initial begin
    #4ms;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    m_axis_tready = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    rst_n = 1'b0;
    sh = '{PH_CLOSED, '0, '0, EPH_FIRST, '0, '0, '0, '0};

    dir_row(req(ACT_CLOSE, '0, '0, '0, '0, '0, '0, '0), 1'b1, quiet(PH_CLOSED, ST_REJECTED));
    dir_row(req(ACT_SEGMENT, '1, '1, '1, '1, '1, '1, '1), 1'b1, quiet(PH_CLOSED, ST_NO_MATCH));
    dir_row(req(ACT_SEND, '0, '0, '0, '0, '0, '0, '1), 1'b1, quiet(PH_CLOSED, ST_REJECTED));
    dir_row(req(ACT_BAD_LO, '0, '0, '0, '0, '0, '0, '0), 1'b1, quiet(PH_CLOSED, ST_REJECTED));
    dir_row(req(ACT_BAD_HI, '1, '1, '1, '1, '1, '1, '1), 1'b1, quiet(PH_CLOSED, ST_REJECTED));
    dir_row(req(ACT_ACTIVE_OPEN, '1, '1, '0, '0, '0, '0, '0), 1'b1,
            result_t'{1'b1, FL_SYN, ACT_ISN_RST, 32'd0, RCV_WIN_RST, EPH_FIRST, 16'hFFFF,
                      32'hFFFF_FFFF, 16'd0, PH_SYN_SENT, ST_OK});
    dir_row(req(ACT_ACTIVE_OPEN, '0, '0, '0, '0, '0, '0, '0), 1'b1,
            quiet(PH_SYN_SENT, ST_REJECTED));
    dir_row(req(ACT_PASSIVE_OPEN, '0, '0, '1, '0, '0, '0, '0), 1'b1,
            quiet(PH_SYN_SENT, ST_REJECTED));
    dir_row(req(ACT_SEGMENT, '0, '1, EPH_FIRST, FL_SYN | FL_ACK, '0, '0, '0), 1'b1,
            quiet(PH_SYN_SENT, ST_NO_MATCH));
    dir_row(req(ACT_SEGMENT, '1, '1, EPH_FIRST, FL_SYN, '0, '0, '0), 1'b0, '0);
    // peer sequence at the top of the range wraps the ack to zero
    dir_row(req(ACT_SEGMENT, '1, '1, EPH_FIRST, FL_SYN | FL_ACK, '1, 32'd1001, '0), 1'b0, '0);
    dir_row(req(ACT_SEND, '0, '0, '0, '0, '0, '0, '1), 1'b0, '0);
    dir_row(req(ACT_SEGMENT, '1, '1, EPH_FIRST, FL_ACK, 32'd5, 32'd1002, 16'd100), 1'b0, '0);
    dir_row(req(ACT_SEGMENT, '1, '1, EPH_FIRST, FL_ACK, 32'd5, 32'd1002, '0), 1'b0, '0);
    dir_row(req(ACT_SEGMENT, '1, '1, EPH_FIRST, FL_PSH, 32'd5, '0, 16'd5), 1'b0, '0);
    dir_row(req(ACT_SEGMENT, '1, '1, EPH_FIRST, FL_FIN | FL_ACK, 32'd12345, '0, '0), 1'b0, '0);
    dir_row(req(ACT_SEND, '0, '0, '0, '0, '0, '0, 16'd10), 1'b1,
            quiet(PH_CLOSE_WAIT, ST_REJECTED));
    dir_row(req(ACT_CLOSE, '0, '0, '0, '0, '0, '0, '0), 1'b0, '0);
    dir_row(req(ACT_SEGMENT, '1, '1, EPH_FIRST, FL_RST, '0, '0, '0), 1'b0, '0);
    dir_row(req(ACT_SEGMENT, '1, '1, EPH_FIRST, FL_ACK, '0, '0, '0), 1'b0, '0);
    dir_row(req(ACT_PASSIVE_OPEN, '1, '1, '0, '0, '0, '0, '0), 1'b1, quiet(PH_LISTEN, ST_OK));
    dir_row(req(ACT_SEGMENT, '0, '0, 16'd1, FL_SYN, '0, '0, '0), 1'b1,
            quiet(PH_LISTEN, ST_NO_MATCH));
    dir_row(req(ACT_SEGMENT, '1, '1, '0, FL_ACK, '0, '0, '0), 1'b0, '0);
    // the listener takes the peer address from the segment source
    dir_row(req(ACT_SEGMENT, 32'h0A00_0001, 16'd1234, '0, FL_SYN, '0, '0, '0), 1'b0, '0);
    dir_row(req(ACT_SEGMENT, 32'h0A00_0001, 16'd1234, '0, FL_ACK, 32'd1, 32'd2001, '0),
            1'b0, '0);

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) offer(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);

    settle();
    program_regs('0, '0, '1, '1);
    repeat (PHASE_ITEMS) offer(make_item(), 1'b0, '0);

    settle();
    snd_idle_pct = 64;
    rcv_idle_pct = 32;
    program_regs('1, '1, '0, '0);
    repeat (PHASE_ITEMS) offer(make_item(), 1'b0, '0);

    settle();
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    program_regs(16'($urandom), 16'($urandom_range(3000)), $urandom, $urandom);
    repeat (PHASE_ITEMS) offer(make_item(), 1'b0, '0);

    // a short run of opens and drops that steps the ephemeral port counter
    while (sh.ph != PH_CLOSED) offer(make_item(), 1'b0, '0);
    repeat (SWEEP_OPENS) begin
      offer(req(ACT_ACTIVE_OPEN, $urandom, 16'($urandom), '0, '0, '0, '0, '0), 1'b0, '0);
      offer(req(ACT_CLOSE, '0, '0, '0, '0, '0, '0, '0), 1'b0, '0);
    end

    // active close, then one of the three ways into time-wait, which is never left
    while (sh.ph != PH_ESTAB) offer(make_item(), 1'b0, '0);
    offer(req(ACT_CLOSE, '0, '0, '0, '0, '0, '0, '0), 1'b0, '0);
    repeat (12) offer(stray_item(~(FL_ACK | FL_FIN)), 1'b0, '0);
    case ($urandom_range(2))
      0: offer(own_seg(FL_FIN | FL_ACK), 1'b0, '0);
      1: begin
        offer(own_seg(FL_ACK), 1'b0, '0);
        repeat (12) offer(stray_item(~FL_FIN), 1'b0, '0);
        offer(own_seg(FL_FIN), 1'b0, '0);
      end
      default: begin
        offer(own_seg(FL_FIN), 1'b0, '0);
        repeat (12) offer(stray_item(~FL_ACK), 1'b0, '0);
        offer(own_seg(FL_ACK), 1'b0, '0);
      end
    endcase
    repeat (16) offer(stray_item(8'hFF), 1'b0, '0);

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_fail == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/tcsm_pkg.sv
rtl/core/tcsm_cfg_regs.sv
rtl/core/tcsm_engine.sv
rtl/core/tcp_connection_state_machine_top.sv
tb/sv/tcp_connection_state_machine_top_test.sv
